// File: rtl/xkrt_pkg.sv
package xkrt_pkg;
  localparam int NUM_BUCKETS = 256;
  localparam int BUCKET_BITS = 8;
  localparam int ID_BITS = 256;
  localparam int DEF_SLOTS_PER_BUCKET = 16;
  localparam int DEF_HANDLE_BITS = 32;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_REM_ID = 3'd1;
  localparam logic [2:0] FN_REM_HANDLE = 3'd2;
  localparam logic [2:0] FN_LOOKUP = 3'd3;
  localparam logic [2:0] FN_BKT_COUNT = 3'd4;
  localparam logic [2:0] FN_BKT_FULL = 3'd5;
  localparam logic [2:0] FN_TOTAL = 3'd6;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_SELF = 3'd4;

  localparam logic [1:0] REG_W0 = 2'd0;
  localparam logic [1:0] REG_W1 = 2'd1;
  localparam logic [1:0] REG_W2 = 2'd2;
  localparam logic [1:0] REG_W3 = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_CLZ, S_FILL, S_SCAN_RD, S_SCAN, S_BKT_NEXT, S_DONE, S_OUT
  } state_t;
endpackage

// File: rtl/xkrt_ram.sv
module xkrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/xkrt_clz.sv
module xkrt_clz (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [255:0] xor_dist,
  output logic       done,
  output logic [8:0] index
);
  logic [255:0] sh_r, sh_nxt;
  logic [8:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;

  always_comb begin
    logic seen;
    seen = 1'b0;
    sh_nxt = sh_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt = xor_dist;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh_r[255:248] != 8'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        for (int i = 0; i < 8; i++) begin
          if (sh_r[255 - i] && !seen) begin
            cnt_nxt = cnt_r + 9'(i);
            seen = 1'b1;
          end
        end
      end else if (cnt_r == 9'd248) begin
        cnt_nxt = 9'd256;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        sh_nxt = {sh_r[247:0], 8'd0};
        cnt_nxt = cnt_r + 9'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sh_r <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign index = cnt_r;
endmodule

// File: rtl/xor_kbucket_routing_table_top.sv
// Peer table of 256 XOR-distance buckets, SLOTS_PER_BUCKET slots each. One
// operation at a time: the bucket index comes from a leading-zero unit that
// steps 8 bits at a time, then a bucket is scanned slot by slot through the
// slot memory read port, each slot read in S_SCAN_RD and checked in S_SCAN.
// Remove by handle scans buckets from 0 up. Bucket and total queries skip
// the scan. A new transfer can be taken from the cycle after the result is
// taken. After reset a clearing pass over every slot and bucket count runs
// before the first item is taken. Local ID words are written through the APB
// port at 8-byte steps.
module xor_kbucket_routing_table_top #(
  parameter int SLOTS_PER_BUCKET = xkrt_pkg::DEF_SLOTS_PER_BUCKET,
  parameter int HANDLE_BITS = xkrt_pkg::DEF_HANDLE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[2:0], id_word_0[66:3], id_word_1[130:67], id_word_2[194:131],
  // id_word_3[258:195], node_handle[290:259], bucket_sel[298:291]
  input  logic [303:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], bucket_index[11:3], found_handle[43:12], entry_count[56:44],
  // is_full[57]
  output logic [63:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int SB = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int NSLOT = xkrt_pkg::NUM_BUCKETS << SB;
  localparam int AW = $clog2(NSLOT);
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int RW = xkrt_pkg::ID_BITS + HANDLE_BITS + 1;

  logic [63:0] lid_r [4];
  xkrt_pkg::state_t st_r, st_nxt;

  logic [2:0]   func_r;
  logic [255:0] id_r;
  logic [HANDLE_BITS-1:0] hdl_r;
  logic [7:0]   sel_r;
  logic [8:0]   bidx_r, bidx_nxt;
  logic [AW:0]  ptr_r, ptr_nxt;
  logic [SB:0]  sl_r, sl_nxt;
  logic         hit_r, hit_nxt;
  logic         fr_r, fr_nxt;
  logic [SB:0]  fs_r, fs_nxt;
  logic [SB-1:0] hs_r, hs_nxt;
  logic [2:0]   status_r, status_nxt;
  logic [31:0]  found_r, found_nxt;
  logic [12:0]  total_r, total_nxt;
  logic [FW-1:0] fill_cur;
  logic         fill_we;
  logic [FW-1:0] fill_wd;
  logic [xkrt_pkg::BUCKET_BITS-1:0] fill_waddr, fill_raddr;
  logic [63:0]  out_r, out_nxt;
  logic         ovld_r, ovld_nxt;

  logic         we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;
  logic         clz_start, clz_done;
  logic [8:0]   clz_idx;

  logic         cfg_wr;
  logic [1:0]   cfg_idx;
  logic         in_fire;

  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[4:3];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = lid_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) lid_r[i] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        xkrt_pkg::REG_W0: lid_r[0] <= cfg_pwdata;
        xkrt_pkg::REG_W1: lid_r[1] <= cfg_pwdata;
        xkrt_pkg::REG_W2: lid_r[2] <= cfg_pwdata;
        xkrt_pkg::REG_W3: lid_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  xkrt_clz u_clz (
    .clk(clk), .rst_n(rst_n), .start(clz_start),
    .xor_dist(id_r ^ {lid_r[0], lid_r[1], lid_r[2], lid_r[3]}),
    .done(clz_done), .index(clz_idx)
  );

  xkrt_ram #(.WIDTH(RW), .DEPTH(NSLOT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  xkrt_ram #(.WIDTH(FW), .DEPTH(xkrt_pkg::NUM_BUCKETS)) u_fill_ram (
    .clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wd),
    .raddr(fill_raddr), .rdata(fill_cur)
  );

  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (st_r == xkrt_pkg::S_IDLE) && !ovld_r;
  assign fill_raddr = (func_r == xkrt_pkg::FN_BKT_COUNT || func_r == xkrt_pkg::FN_BKT_FULL)
                      ? sel_r : bidx_r[7:0];
  assign raddr = {bidx_r[7:0], sl_r[SB-1:0]};

  always_comb begin
    st_nxt = st_r;
    bidx_nxt = bidx_r;
    ptr_nxt = ptr_r;
    sl_nxt = sl_r;
    hit_nxt = hit_r;
    fr_nxt = fr_r;
    fs_nxt = fs_r;
    hs_nxt = hs_r;
    status_nxt = status_r;
    found_nxt = found_r;
    total_nxt = total_r;
    out_nxt = out_r;
    ovld_nxt = ovld_r;
    clz_start = 1'b0;
    we = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = '0;
    fill_we = 1'b0;
    fill_waddr = bidx_r[7:0];
    fill_wd = fill_cur;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    case (st_r)
      xkrt_pkg::S_FILL: begin
        we = 1'b1;
        fill_we = 1'b1;
        fill_waddr = ptr_r[7:0];
        fill_wd = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == (AW+1)'(NSLOT - 1)) st_nxt = xkrt_pkg::S_IDLE;
      end
      xkrt_pkg::S_IDLE: begin
        if (in_fire) begin
          status_nxt = xkrt_pkg::ST_OK;
          found_nxt = '0;
          hit_nxt = 1'b0;
          fr_nxt = 1'b0;
          fs_nxt = '0;
          sl_nxt = '0;
          bidx_nxt = '0;
          case (in_tdata[2:0])
            xkrt_pkg::FN_ADD, xkrt_pkg::FN_REM_ID, xkrt_pkg::FN_LOOKUP: begin
              st_nxt = xkrt_pkg::S_CLZ;
            end
            xkrt_pkg::FN_REM_HANDLE: begin
              status_nxt = xkrt_pkg::ST_NOT_FOUND;
              st_nxt = xkrt_pkg::S_SCAN_RD;
            end
            xkrt_pkg::FN_BKT_COUNT, xkrt_pkg::FN_BKT_FULL,
            xkrt_pkg::FN_TOTAL: st_nxt = xkrt_pkg::S_DONE;
            default: begin
              status_nxt = xkrt_pkg::ST_NOT_FOUND;
              st_nxt = xkrt_pkg::S_DONE;
            end
          endcase
        end
      end
      xkrt_pkg::S_CLZ: begin
        if (!clz_done && !hit_r) begin
          clz_start = 1'b1;
          hit_nxt = 1'b1;
        end else if (clz_done) begin
          hit_nxt = 1'b0;
          bidx_nxt = clz_idx;
          if (clz_idx[8]) begin
            status_nxt = (func_r == xkrt_pkg::FN_ADD) ? xkrt_pkg::ST_SELF
                                                       : xkrt_pkg::ST_NOT_FOUND;
            st_nxt = xkrt_pkg::S_DONE;
          end else begin
            st_nxt = xkrt_pkg::S_SCAN_RD;
          end
        end
      end
      xkrt_pkg::S_SCAN_RD: st_nxt = xkrt_pkg::S_SCAN;
      xkrt_pkg::S_SCAN: begin
        if (rdata[0]) begin
          if (func_r == xkrt_pkg::FN_REM_HANDLE) begin
            if (rdata[HANDLE_BITS:1] == hdl_r) begin
              we = 1'b1;
              waddr = raddr;
              hit_nxt = 1'b1;
              fs_nxt = fs_r + 1'b1;
            end
          end else if (rdata[RW-1:HANDLE_BITS+1] == id_r && !hit_r) begin
            hit_nxt = 1'b1;
            hs_nxt = sl_r[SB-1:0];
            found_nxt = 32'(rdata[HANDLE_BITS:1]);
          end
        end else if (!fr_r) begin
          fr_nxt = 1'b1;
          if (func_r != xkrt_pkg::FN_REM_HANDLE) fs_nxt = {1'b0, sl_r[SB-1:0]};
        end
        sl_nxt = sl_r + 1'b1;
        if (sl_r == (SB+1)'(SLOTS_PER_BUCKET - 1)) st_nxt = xkrt_pkg::S_BKT_NEXT;
        else st_nxt = xkrt_pkg::S_SCAN_RD;
      end
      xkrt_pkg::S_BKT_NEXT: begin
        st_nxt = xkrt_pkg::S_DONE;
        sl_nxt = '0;
        case (func_r)
          xkrt_pkg::FN_REM_HANDLE: begin
            if (hit_r) begin
              status_nxt = xkrt_pkg::ST_OK;
              fill_we = 1'b1;
              fill_wd = fill_cur - FW'(fs_r);
              total_nxt = total_r - 13'(fs_r);
            end else if (bidx_r[7:0] != 8'hff) begin
              bidx_nxt = bidx_r + 1'b1;
              st_nxt = xkrt_pkg::S_SCAN_RD;
            end else begin
              bidx_nxt = '0;
            end
            fs_nxt = '0;
          end
          xkrt_pkg::FN_ADD: begin
            if (hit_r) status_nxt = xkrt_pkg::ST_DUP;
            else if (!fr_r) status_nxt = xkrt_pkg::ST_FULL;
            else begin
              we = 1'b1;
              waddr = {bidx_r[7:0], fs_r[SB-1:0]};
              wdata = {id_r, hdl_r, 1'b1};
              fill_we = 1'b1;
              fill_wd = fill_cur + 1'b1;
              total_nxt = total_r + 1'b1;
            end
            found_nxt = '0;
          end
          xkrt_pkg::FN_REM_ID: begin
            found_nxt = '0;
            if (!hit_r) status_nxt = xkrt_pkg::ST_NOT_FOUND;
            else begin
              we = 1'b1;
              waddr = {bidx_r[7:0], hs_r};
              fill_we = 1'b1;
              fill_wd = fill_cur - 1'b1;
              total_nxt = total_r - 1'b1;
            end
          end
          default: begin
            if (!hit_r) status_nxt = xkrt_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      xkrt_pkg::S_DONE: begin
        if (func_r == xkrt_pkg::FN_BKT_COUNT || func_r == xkrt_pkg::FN_BKT_FULL) begin
          bidx_nxt = {1'b0, sel_r};
        end
        st_nxt = xkrt_pkg::S_OUT;
      end
      xkrt_pkg::S_OUT: begin
        out_nxt = '0;
        out_nxt[2:0] = status_r;
        out_nxt[11:3] = bidx_r;
        out_nxt[43:12] = found_r;
        if (func_r == xkrt_pkg::FN_BKT_COUNT || func_r == xkrt_pkg::FN_BKT_FULL) begin
          out_nxt[56:44] = 13'(fill_cur);
          out_nxt[57] = (fill_cur == FW'(SLOTS_PER_BUCKET));
        end else begin
          out_nxt[56:44] = total_r;
          if ((func_r == xkrt_pkg::FN_ADD || func_r == xkrt_pkg::FN_REM_ID ||
               func_r == xkrt_pkg::FN_LOOKUP) && !bidx_r[8]) begin
            out_nxt[57] = (fill_cur == FW'(SLOTS_PER_BUCKET));
          end
        end
        ovld_nxt = 1'b1;
        st_nxt = xkrt_pkg::S_IDLE;
      end
      default: st_nxt = xkrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= xkrt_pkg::S_FILL;
      ptr_r <= '0;
      total_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      total_r <= total_nxt;
      ovld_r <= ovld_nxt;
    end
    if (in_fire) begin
      func_r <= in_tdata[2:0];
      id_r <= {in_tdata[66:3], in_tdata[130:67], in_tdata[194:131], in_tdata[258:195]};
      hdl_r <= HANDLE_BITS'(in_tdata[290:259]);
      sel_r <= in_tdata[298:291];
    end
    bidx_r <= bidx_nxt;
    sl_r <= sl_nxt;
    hit_r <= hit_nxt;
    fr_r <= fr_nxt;
    fs_r <= fs_nxt;
    hs_r <= hs_nxt;
    status_r <= status_nxt;
    found_r <= found_nxt;
    out_r <= out_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = out_r;
endmodule

// File: rtl/xkrt_checker.sv
module xkrt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_one_at_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("bad status code");
  a_no_ready_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("ready while result pending");
endmodule

bind xor_kbucket_routing_table_top xkrt_checker u_xkrt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// File: tb/sv/xor_kbucket_routing_table_top_tb.sv
module xor_kbucket_routing_table_top_tb;

  localparam int SLOTS = xkrt_pkg::DEF_SLOTS_PER_BUCKET;
  localparam int NB = xkrt_pkg::NUM_BUCKETS;
  localparam int LIMIT_CYCLES = 6000000;
  localparam logic [2:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0]  bucket_sel;
    logic [31:0] node_handle;
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
    logic [2:0]  func;
  } op_t;

  typedef struct packed {
    logic        is_full;
    logic [12:0] entry_count;
    logic [31:0] found_handle;
    logic [8:0]  bkt_idx;
    logic [2:0]  status;
  } rsp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [303:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  xor_kbucket_routing_table_top dut (.*);

  initial forever #4 clk = ~clk;

  logic [255:0] my_id;
  logic [255:0] peer_id [NB*SLOTS];
  logic [31:0] peer_handle [NB*SLOTS];
  bit peer_used [NB*SLOTS];
  int fill [NB];
  int total;

  op_t pending_ops[$];
  rsp_t expected_rsp[$];
  logic [255:0] known_ids[$];
  logic [31:0] known_handles[$];
  int errors = 0, cycles = 0;
  int in_gap = 0, out_gap = 0;

  function automatic int xor_bucket(logic [255:0] id);
    logic [255:0] x;
    x = id ^ my_id;
    for (int i = 0; i < 256; i++)
      if (x[255-i]) return i;
    return 256;
  endfunction

  function automatic int slot_of(int b, logic [255:0] id);
    for (int s = 0; s < SLOTS; s++)
      if (peer_used[b*SLOTS+s] && peer_id[b*SLOTS+s] == id) return b*SLOTS+s;
    return -1;
  endfunction

  function automatic rsp_t apply_op(op_t op);
    rsp_t r;
    logic [255:0] id;
    int b, hit;
    bit done;
    r = '0;
    id = {op.w0, op.w1, op.w2, op.w3};
    case (op.func)
      xkrt_pkg::FN_ADD, xkrt_pkg::FN_REM_ID, xkrt_pkg::FN_LOOKUP: begin
        b = xor_bucket(id);
        r.bkt_idx = 9'(b);
        if (b == 256) begin
          r.status = (op.func == xkrt_pkg::FN_ADD) ? xkrt_pkg::ST_SELF
                                                   : xkrt_pkg::ST_NOT_FOUND;
        end else begin
          hit = slot_of(b, id);
          if (op.func == xkrt_pkg::FN_ADD) begin
            if (hit >= 0) r.status = xkrt_pkg::ST_DUP;
            else if (fill[b] >= SLOTS) r.status = xkrt_pkg::ST_FULL;
            else begin
              done = 0;
              for (int s = 0; s < SLOTS && !done; s++)
                if (!peer_used[b*SLOTS+s]) begin
                  peer_used[b*SLOTS+s] = 1;
                  peer_id[b*SLOTS+s] = id;
                  peer_handle[b*SLOTS+s] = op.node_handle;
                  done = 1;
                end
              fill[b]++;
              total++;
              r.status = xkrt_pkg::ST_OK;
            end
          end else if (hit < 0) begin
            r.status = xkrt_pkg::ST_NOT_FOUND;
          end else if (op.func == xkrt_pkg::FN_REM_ID) begin
            peer_used[hit] = 0;
            fill[b]--;
            total--;
            r.status = xkrt_pkg::ST_OK;
          end else begin
            r.found_handle = peer_handle[hit];
            r.status = xkrt_pkg::ST_OK;
          end
          r.is_full = fill[b] >= SLOTS;
        end
        r.entry_count = 13'(total);
      end
      xkrt_pkg::FN_REM_HANDLE: begin
        r.status = xkrt_pkg::ST_NOT_FOUND;
        for (int bb = 0; bb < NB && r.status != xkrt_pkg::ST_OK; bb++)
          for (int s = 0; s < SLOTS; s++)
            if (peer_used[bb*SLOTS+s] && peer_handle[bb*SLOTS+s] == op.node_handle) begin
              peer_used[bb*SLOTS+s] = 0;
              fill[bb]--;
              total--;
              r.status = xkrt_pkg::ST_OK;
              r.bkt_idx = 9'(bb);
            end
        r.entry_count = 13'(total);
      end
      xkrt_pkg::FN_BKT_COUNT, xkrt_pkg::FN_BKT_FULL: begin
        r.bkt_idx = {1'b0, op.bucket_sel};
        r.entry_count = 13'(fill[op.bucket_sel]);
        r.is_full = fill[op.bucket_sel] >= SLOTS;
      end
      xkrt_pkg::FN_TOTAL: r.entry_count = 13'(total);
      default: begin
        r.status = xkrt_pkg::ST_NOT_FOUND;
        r.entry_count = 13'(total);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_rsp.push_front(apply_op(op_t'(in_tdata[298:0])));
        in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (pending_ops.size() > 0 && $urandom_range(0, 3) == 0) begin
          in_tvalid <= 1;
          in_tdata <= {5'b0, pending_ops.pop_back()};
        end else begin
          in_tvalid <= 0;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        else if (pending_ops.size() > 0) begin
          in_tvalid <= 1;
          in_tdata <= {5'b0, pending_ops.pop_back()};
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t got, want;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = rsp_t'(out_tdata[57:0]);
        if (expected_rsp.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_rsp.pop_back();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display({"mismatch: exp st=%0d bi=%0d fh=%h ec=%0d f=%0d",
                        " got st=%0d bi=%0d fh=%h ec=%0d f=%0d"},
                       want.status, want.bkt_idx, want.found_handle,
                       want.entry_count, want.is_full, got.status, got.bkt_idx,
                       got.found_handle, got.entry_count, got.is_full);
          end
        end
        out_gap <= $urandom_range(0, 17);
        out_tready <= 0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
      if (cycles > LIMIT_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [255:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [255:0] id_in_bucket(int b);
    logic [255:0] r;
    r = rand_id();
    r = r >> b;
    r[255-b] = 1'b1;
    return r ^ my_id;
  endfunction

  function automatic op_t make_op(logic [2:0] f, logic [255:0] id, logic [31:0] h,
                                  logic [7:0] sel);
    op_t o;
    o.func = f;
    {o.w0, o.w1, o.w2, o.w3} = id;
    o.node_handle = h;
    o.bucket_sel = sel;
    return o;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      xkrt_pkg::REG_W0: my_id[255:192] = val;
      xkrt_pkg::REG_W1: my_id[191:128] = val;
      xkrt_pkg::REG_W2: my_id[127:64] = val;
      default: my_id[63:0] = val;
    endcase
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || in_tvalid || expected_rsp.size() > 0) @(posedge clk);
    repeat (9000) @(posedge clk);
  endtask

  task automatic set_local(logic [255:0] v);
    cfg_write(xkrt_pkg::REG_W0, v[255:192]);
    cfg_write(xkrt_pkg::REG_W1, v[191:128]);
    cfg_write(xkrt_pkg::REG_W2, v[127:64]);
    cfg_write(xkrt_pkg::REG_W3, v[63:0]);
  endtask

  task automatic add_random(int n);
    logic [255:0] id;
    logic [31:0] h;
    int b, k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
      id = id_in_bucket(b);
      h = (known_handles.size() > 0 && $urandom_range(0, 1))
          ? known_handles[$urandom_range(0, known_handles.size()-1)] : $urandom;
      if (k < 40) begin
        if ($urandom_range(0, 4) == 0 && known_ids.size() > 0)
          id = known_ids[$urandom_range(0, known_ids.size()-1)];
        known_ids.push_front(id);
        known_handles.push_front(h);
        pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, id, h, '0));
      end else if (k < 75) begin
        if (known_ids.size() > 0 && $urandom_range(0, 3) != 0)
          id = known_ids[$urandom_range(0, known_ids.size()-1)];
        pending_ops.push_front(make_op(k < 55 ? xkrt_pkg::FN_LOOKUP : xkrt_pkg::FN_REM_ID,
                                       id, h, '0));
      end else if (k < 82) begin
        pending_ops.push_front(make_op(xkrt_pkg::FN_REM_HANDLE, rand_id(), h, '0));
      end else if (k < 96) begin
        pending_ops.push_front(make_op(
            3'($urandom_range(xkrt_pkg::FN_BKT_COUNT, xkrt_pkg::FN_TOTAL)), rand_id(), h,
            8'($urandom_range(0, 3) ? $urandom_range(0, 5) : $urandom)));
      end else begin
        pending_ops.push_front(make_op(FN_UNUSED, rand_id(), h, 8'($urandom)));
      end
    end
  endtask

  initial begin
    my_id = '0;
    total = 0;
    for (int i = 0; i < NB; i++) fill[i] = 0;
    for (int i = 0; i < NB*SLOTS; i++) peer_used[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    set_local({64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1});

    pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, my_id, 32'hFFFF_FFFF, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_REM_ID, my_id, '0, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_LOOKUP, my_id, '0, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, ~my_id, 32'hFFFF_FFFF, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, my_id ^ 256'h1, 32'h0, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, my_id ^ 256'h1, 32'h5, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_LOOKUP, my_id ^ 256'h1, '0, '0));
    for (int i = 0; i < SLOTS + 1; i++)
      pending_ops.push_front(make_op(xkrt_pkg::FN_ADD, id_in_bucket(3), 32'h77, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_BKT_FULL, '0, '0, 8'd3));
    pending_ops.push_front(make_op(xkrt_pkg::FN_BKT_COUNT, '0, '0, 8'd255));
    pending_ops.push_front(make_op(xkrt_pkg::FN_REM_HANDLE, '0, 32'h77, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_REM_HANDLE, '0, 32'h1234, '0));
    pending_ops.push_front(make_op(xkrt_pkg::FN_TOTAL, '0, '0, '0));
    pending_ops.push_front(make_op(FN_UNUSED, '1, '1, '1));
    drain();

    add_random(350);
    drain();
    set_local('1);
    add_random(350);
    drain();
    set_local('0);
    add_random(420);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
